// ===== design/arc_pkg.sv =====
// arc_pkg: shared types and constants of the arp responder with ip-to-mac cache
// used by arc_cell and arp_responder_cache_core; depends on nothing else
package arc_pkg;

  // message checks
  localparam int          MESSAGE_BYTES = 28;
  localparam logic [15:0] HW_TYPE_ETH   = 16'h0100;
  localparam logic [15:0] PROTO_IPV4    = 16'h0008;
  localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IP  = 8'd4;

  // raw opcodes
  localparam logic [15:0] OPC_REQUEST   = 16'h0100;
  localparam logic [15:0] OPC_REPLY     = 16'h0200;

  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

  // operation codes of an input beat
  localparam logic        OPER_MESSAGE  = 1'b0;
  localparam logic        OPER_RESOLVE  = 1'b1;

  // result kinds
  localparam logic [2:0]  KIND_IGNORED  = 3'd0;
  localparam logic [2:0]  KIND_REPLIED  = 3'd1;
  localparam logic [2:0]  KIND_CACHED   = 3'd2;
  localparam logic [2:0]  KIND_FULL     = 3'd3;
  localparam logic [2:0]  KIND_LOOKUP   = 3'd4;

  // configuration register indexes
  localparam logic        REG_OWN_IP    = 1'b0;
  localparam logic        REG_OWN_MAC   = 1'b1;

  // lookup token that walks down the cell chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] ip;
    logic [47:0] mac;
  } scan_t;

  // append request broadcast to all cells
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } write_t;

endpackage

// ===== design/arc_cell.sv =====
// arc_cell: one cache entry of the chain, holding an ip/mac pair and passing
// the lookup token on to its neighbor each cycle; depends on arc_pkg
module arc_cell #(
  parameter int IDX_W = 7,
  parameter int CNT_W = 8,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  arc_pkg::write_t     wr,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [CNT_W-1:0]    count,
  input  arc_pkg::scan_t      scan_in,
  output arc_pkg::scan_t      scan_out
);

  logic [31:0]    entry_ip;
  logic [47:0]    entry_mac;
  logic           filled;
  arc_pkg::scan_t scan_next;

  // entry storage, written when the append lands on this slot
  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IDX_W'(INDEX))) begin
      entry_ip  <= wr.ip;
      entry_mac <= wr.mac;
    end
  end

  // only slots below the fill count take part in a lookup
  assign filled = (CNT_W'(INDEX) < count);

  // first match wins: a token that already found keeps its mac
  always_comb begin
    scan_next = scan_in;
    if (scan_in.valid && !scan_in.found && filled && (entry_ip == scan_in.ip)) begin
      scan_next.found = 1'b1;
      scan_next.mac   = entry_mac;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out <= scan_next;
    end
  end

endmodule

// ===== design/arp_responder_cache_core.sv =====
// arp_responder_cache_core: arp responder with an ip-to-mac cache built as a
// chain of cells; depends on arc_pkg and arc_cell
//
// Usage:
//   An input beat (a parsed arp message or a resolve query) is taken at a
//   rising edge with start high and busy low. Every beat gives exactly one
//   result, shown for one cycle with done high; the receiver cannot stall it.
//   own_ip and own_mac are written through cfg_we / cfg_index / cfg_data
//   while the block is idle.
// Message and query flow:
//   A message gives its result in the cycle after it is taken and busy stays
//   low, so messages may follow each other every cycle. A valid reply
//   message is appended to the cache at the edge that takes it, unless the
//   cache is full. A resolve query walks a token through the CACHE_ENTRIES
//   cells, one cell a cycle, and its result is shown with done once the token
//   has left the last cell; busy is high for that whole walk, and the next
//   beat can be taken at the edge that ends the result cycle.
// Reset:
//   rst clears the fill count, the registers own_ip and own_mac, the scan
//   state and done. The cache contents need no clearing since only filled
//   slots are compared.
module arp_responder_cache_core #(
  parameter int CACHE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [10:0] payload_size,
  input  logic [15:0] hardware_type,
  input  logic [15:0] protocol_type,
  input  logic [7:0]  hw_addr_len,
  input  logic [7:0]  proto_addr_len,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [47:0] target_mac,
  input  logic [31:0] target_ip,
  // result channel
  output logic        done,
  output logic [2:0]  result_kind,
  output logic        send_frame,
  output logic [15:0] frame_opcode,
  output logic [47:0] frame_sender_mac,
  output logic [31:0] frame_sender_ip,
  output logic [47:0] frame_target_mac,
  output logic [31:0] frame_target_ip,
  output logic        lookup_hit,
  output logic [47:0] lookup_mac,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [31:0]     own_ip;
  logic [47:0]     own_mac;
  logic [CNT_W-1:0] entry_count;
  logic            accept;
  logic            lookup_accept;
  logic            msg_ok;
  logic            cache_full;
  arc_pkg::write_t wr;
  arc_pkg::scan_t  inject;
  arc_pkg::scan_t  link [CACHE_ENTRIES+1];
  arc_pkg::scan_t  chain_end;
  logic            end_hit;

  // result fields before the output register
  logic [2:0]      kind_next;
  logic            send_next;
  logic [15:0]     opc_next;
  logic [47:0]     tmac_next;
  logic [31:0]     tip_next;
  logic            hit_next;
  logic [47:0]     lmac_next;
  logic            done_next;

  assign busy          = (state == ST_SCAN);
  assign accept        = start && !busy;
  assign lookup_accept = accept && (operation == arc_pkg::OPER_RESOLVE);
  assign cache_full    = (entry_count >= CNT_W'(CACHE_ENTRIES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arc_pkg::REG_OWN_IP:  own_ip  <= cfg_data[31:0];
        arc_pkg::REG_OWN_MAC: own_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  // header checks of a received message
  assign msg_ok = (payload_size >= 11'(arc_pkg::MESSAGE_BYTES))
               && (hardware_type == arc_pkg::HW_TYPE_ETH)
               && (protocol_type == arc_pkg::PROTO_IPV4)
               && (hw_addr_len == arc_pkg::HW_LEN_ETH)
               && (proto_addr_len == arc_pkg::PROTO_LEN_IP)
               && (target_ip == own_ip);

  // append of a valid reply into the next free slot
  assign wr.en  = accept && (operation == arc_pkg::OPER_MESSAGE) && msg_ok
               && (opcode == arc_pkg::OPC_REPLY) && !cache_full;
  assign wr.ip  = sender_ip;
  assign wr.mac = sender_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr.en) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // token launch into the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      inject.valid <= 1'b0;
    end else begin
      inject.valid <= lookup_accept;
      inject.found <= 1'b0;
      inject.ip    <= target_ip;
      inject.mac   <= arc_pkg::BCAST_MAC;
    end
  end

  // chain of cache cells
  assign link[0] = inject;

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    arc_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr),
      .wr_idx   (entry_count[IDX_W-1:0]),
      .count    (entry_count),
      .scan_in  (link[k]),
      .scan_out (link[k+1])
    );
  end

  assign chain_end = link[CACHE_ENTRIES];
  // a cached broadcast mac counts as a miss
  assign end_hit   = chain_end.found && (chain_end.mac != arc_pkg::BCAST_MAC);

  // scan control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (lookup_accept) state_next = ST_SCAN;
      ST_SCAN: if (chain_end.valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result of this cycle: end of a lookup walk or a message just taken
  always_comb begin
    done_next = 1'b0;
    kind_next = arc_pkg::KIND_IGNORED;
    send_next = 1'b0;
    opc_next  = '0;
    tmac_next = '0;
    tip_next  = '0;
    hit_next  = 1'b0;
    lmac_next = '0;
    if (chain_end.valid) begin
      done_next = 1'b1;
      kind_next = arc_pkg::KIND_LOOKUP;
      hit_next  = end_hit;
      lmac_next = chain_end.mac;
      if (!end_hit) begin
        send_next = 1'b1;
        opc_next  = arc_pkg::OPC_REQUEST;
        tmac_next = arc_pkg::BCAST_MAC;
        tip_next  = chain_end.ip;
      end
    end else if (accept && (operation == arc_pkg::OPER_MESSAGE)) begin
      done_next = 1'b1;
      if (msg_ok && (opcode == arc_pkg::OPC_REQUEST)) begin
        kind_next = arc_pkg::KIND_REPLIED;
        send_next = 1'b1;
        opc_next  = arc_pkg::OPC_REPLY;
        tmac_next = sender_mac;
        tip_next  = sender_ip;
      end else if (msg_ok && (opcode == arc_pkg::OPC_REPLY)) begin
        kind_next = cache_full ? arc_pkg::KIND_FULL : arc_pkg::KIND_CACHED;
      end
    end
  end

  // result register, one beat per done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done             <= done_next;
      result_kind      <= kind_next;
      send_frame       <= send_next;
      frame_opcode     <= opc_next;
      frame_sender_mac <= send_next ? own_mac : 48'd0;
      frame_sender_ip  <= send_next ? own_ip : 32'd0;
      frame_target_mac <= tmac_next;
      frame_target_ip  <= tip_next;
      lookup_hit       <= hit_next;
      lookup_mac       <= lmac_next;
    end
  end

  // the token only leaves the chain while a lookup is in progress
  assert property (@(posedge clk) disable iff (rst)
    chain_end.valid |-> (state == ST_SCAN))
    else $error("lookup token left the chain outside a scan");

  // the fill count never passes the cache size
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CACHE_ENTRIES))
    else $error("cache fill count overflow");

  // a taken resolve query holds the command channel busy
  assert property (@(posedge clk) disable iff (rst)
    lookup_accept |=> busy)
    else $error("busy not raised after a resolve query");

  // a lookup result is always preceded by the token reaching the chain end
  assert property (@(posedge clk) disable iff (rst)
    (done && (result_kind == arc_pkg::KIND_LOOKUP)) |-> $past(chain_end.valid))
    else $error("lookup result without a finished scan");

endmodule
